// ===== hw/rtl/parabola_pair_intersection_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the parabola pair intersection block
// Implication checks on the same cycle and on the following cycle.
// ----------------------------------------------------------------------------
`ifndef PARABOLA_PAIR_INTERSECTION_TOP_MACROS_SVH
`define PARABOLA_PAIR_INTERSECTION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ppi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppi_pkg
// Widths, status codes and pipeline side-band types of the intersection block.
// ----------------------------------------------------------------------------
package ppi_pkg;

  // Dividend, divisor and quotient widths of the rounding dividers.
  localparam int NUM_W  = 68;
  localparam int DEN_W  = 34;
  localparam int QUO_W  = 32;
  // Radicand and root widths of the square root unit.
  localparam int E_W    = 130;
  localparam int ROOT_W = 65;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SITE = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    logic site;   // a site lies on the directrix
    logic azero;  // both sites at the same height
    logic same;   // equal x of the sites
    logic eneg;   // discriminant negative
    logic ezero;  // discriminant zero
  } flags_t;

  // Travels alongside the square root.
  typedef struct packed {
    logic signed [65:0] b;
    logic signed [33:0] a;
    logic signed [32:0] xsum;
    logic signed [32:0] d1;
    logic signed [32:0] spl;
    logic signed [31:0] s1x;
    flags_t             flags;
  } sq_side_t;

  // Travels alongside the x dividers.
  typedef struct packed {
    logic signed [32:0] d1;
    logic signed [32:0] spl;
    logic signed [31:0] s1x;
    logic [1:0]         cnt;
    logic               site;
  } xside_t;

  // Travels alongside the y dividers.
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic               sat1;
    logic               sat2;
    logic [1:0]         cnt;
    logic               site;
  } yside_t;

endpackage

// ===== hw/rtl/ppi_div.sv =====
// ----------------------------------------------------------------------------
// ppi_div
// Two-lane pipelined restoring divider with a shared divisor, rounding to
// nearest (ties away from zero) and saturation to a signed 32-bit quotient.
// ----------------------------------------------------------------------------
module ppi_div #(
  parameter int SB_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic signed [ppi_pkg::NUM_W-1:0]    num1_i,
  input  logic signed [ppi_pkg::NUM_W-1:0]    num2_i,
  input  logic signed [ppi_pkg::DEN_W-1:0]    den_i,
  input  logic [SB_W-1:0]                     side_i,
  output logic                                vld_o,
  output logic signed [ppi_pkg::QUO_W-1:0]    quo1_o,
  output logic signed [ppi_pkg::QUO_W-1:0]    quo2_o,
  output logic                                sat1_o,
  output logic                                sat2_o,
  output logic [SB_W-1:0]                     side_o
);
  import ppi_pkg::*;

  localparam int QB  = QUO_W + 1;
  localparam int PAD = NUM_W - DEN_W - QB;
  localparam logic [QB:0] LIM_POS = {{(QB - QUO_W + 2){1'b0}}, {(QUO_W - 1){1'b1}}};
  localparam logic [QB:0] LIM_NEG = LIM_POS + (QB + 1)'(1);
  localparam logic [QUO_W-1:0] QMAX = {1'b0, {(QUO_W - 1){1'b1}}};
  localparam logic [QUO_W-1:0] QMIN = {1'b1, {(QUO_W - 1){1'b0}}};

  logic [1:0][NUM_W-1:0] num_in;
  logic [1:0][NUM_W-1:0] nm_d;
  logic [DEN_W-1:0]      dm_d;
  logic [1:0]            neg_d, ovf_d;

  logic [1:0][NUM_W-1:0] rem0_q;
  logic [DEN_W-1:0]      dm0_q;
  logic [1:0]            neg0_q, ovf0_q;
  logic [SB_W-1:0]       side0_q;
  logic                  vld0_q;

  logic [1:0][NUM_W-1:0] rem_q  [QB];
  logic [1:0][QB-1:0]    quo_q  [QB];
  logic [DEN_W-1:0]      dm_q   [QB];
  logic [1:0]            neg_q  [QB];
  logic [1:0]            ovf_q  [QB];
  logic [SB_W-1:0]       side_q [QB];
  logic                  vld_q  [QB];

  logic [1:0][QB:0]      qr;
  logic [1:0]            rnd, sat_d;
  logic [1:0][QUO_W-1:0] res_d;

  logic                  vld_out_q;
  logic [1:0][QUO_W-1:0] res_q;
  logic [1:0]            sat_q;
  logic [SB_W-1:0]       side_out_q;

  assign num_in = {num2_i, num1_i};

  // Magnitudes, signs and the early overflow check (quotient of 2^33 or more).
  always_comb begin
    dm_d = den_i[DEN_W-1] ? (~den_i + DEN_W'(1)) : den_i;
    for (int l = 0; l < 2; l++) begin
      nm_d[l]  = num_in[l][NUM_W-1] ? (~num_in[l] + NUM_W'(1)) : num_in[l];
      neg_d[l] = num_in[l][NUM_W-1] ^ den_i[DEN_W-1];
      ovf_d[l] = nm_d[l] >= {{PAD{1'b0}}, dm_d, {QB{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem0_q  <= nm_d;
    dm0_q   <= dm_d;
    neg0_q  <= neg_d;
    ovf0_q  <= ovf_d;
    side0_q <= side_i;
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [1:0][NUM_W-1:0] rem_in;
    logic [1:0][QB-1:0]    quo_in;
    logic [DEN_W-1:0]      dm_in;
    logic [1:0]            neg_in, ovf_in;
    logic [SB_W-1:0]       side_in;
    logic                  vld_in;
    logic [NUM_W-1:0]      trial;

    if (i == 0) begin : g_head
      assign rem_in  = rem0_q;
      assign quo_in  = '0;
      assign dm_in   = dm0_q;
      assign neg_in  = neg0_q;
      assign ovf_in  = ovf0_q;
      assign side_in = side0_q;
      assign vld_in  = vld0_q;
    end else begin : g_tail
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign dm_in   = dm_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign ovf_in  = ovf_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign trial = {{(NUM_W - DEN_W){1'b0}}, dm_in} << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int l = 0; l < 2; l++) begin
        if (rem_in[l] >= trial) begin
          rem_q[i][l] <= rem_in[l] - trial;
          quo_q[i][l] <= {quo_in[l][QB-2:0], 1'b1};
        end else begin
          rem_q[i][l] <= rem_in[l];
          quo_q[i][l] <= {quo_in[l][QB-2:0], 1'b0};
        end
      end
      dm_q[i]   <= dm_in;
      neg_q[i]  <= neg_in;
      ovf_q[i]  <= ovf_in;
      side_q[i] <= side_in;
    end
  end

  // Round on twice the remainder, restore the sign and saturate.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l]   = {rem_q[QB-1][l][DEN_W-1:0], 1'b0} >= {1'b0, dm_q[QB-1]};
      qr[l]    = {1'b0, quo_q[QB-1][l]} + (QB + 1)'(rnd[l]);
      sat_d[l] = ovf_q[QB-1][l] || (neg_q[QB-1][l] ? (qr[l] > LIM_NEG) : (qr[l] > LIM_POS));
      if (sat_d[l]) begin
        res_d[l] = neg_q[QB-1][l] ? QMIN : QMAX;
      end else if (neg_q[QB-1][l]) begin
        res_d[l] = ~qr[l][QUO_W-1:0] + QUO_W'(1);
      end else begin
        res_d[l] = qr[l][QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    sat_q      <= sat_d;
    side_out_q <= side_q[QB-1];
  end

  assign vld_o  = vld_out_q;
  assign quo1_o = res_q[0];
  assign quo2_o = res_q[1];
  assign sat1_o = sat_q[0];
  assign sat2_o = sat_q[1];
  assign side_o = side_out_q;

endmodule

// ===== hw/rtl/ppi_sqrt.sv =====
// ----------------------------------------------------------------------------
// ppi_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module ppi_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [ppi_pkg::E_W-1:0]       rad_i,
  input  logic [SB_W-1:0]               side_i,
  output logic                          vld_o,
  output logic [ppi_pkg::ROOT_W-1:0]    root_o,
  output logic [SB_W-1:0]               side_o
);
  import ppi_pkg::*;

  logic [E_W-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SB_W-1:0]   side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [E_W-1:0]    rem_in, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SB_W-1:0]   side_in;
    logic              vld_in;

    if (i == 0) begin : g_head
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_tail
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // Growth of the square when bit K is added to the partial root.
    assign trial = ({{(E_W - ROOT_W){1'b0}}, root_in} << (K + 1))
                 | ({{(E_W - 1){1'b0}}, 1'b1} << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[i]  <= rem_in - trial;
        root_q[i] <= root_in | (ROOT_W'(1) << K);
      end else begin
        rem_q[i]  <= rem_in;
        root_q[i] <= root_in;
      end
      side_q[i] <= side_in;
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

// ===== hw/rtl/parabola_pair_intersection_top.sv =====
// ----------------------------------------------------------------------------
// parabola_pair_intersection_top
// Common points of two parabolas sharing a horizontal directrix, Q16.16.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake              | Payload
//  ----------+-----------+------------------------+-------------------------------
//  sites     | in        | start high, busy low   | site1/site2 x, y, directrix_y
//  points    | out       | done_o strobe, 1 cycle | count, two points, status
//
// One transaction enters every clock cycle; busy is never raised.
// The path runs through the 65-stage square root and the two
// 35-stage rounding dividers (x, then y) around the multiplier stages.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "parabola_pair_intersection_top_macros.svh"

module parabola_pair_intersection_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         site1_x_i,
  input  logic signed [31:0]         site1_y_i,
  input  logic signed [31:0]         site2_x_i,
  input  logic signed [31:0]         site2_y_i,
  input  logic signed [31:0]         directrix_y_i,
  output logic                       done_o,
  output logic [1:0]                 point_count_o,
  output logic signed [31:0]         point1_x_o,
  output logic signed [31:0]         point1_y_o,
  output logic signed [31:0]         point2_x_o,
  output logic signed [31:0]         point2_y_o,
  output ppi_pkg::status_e           status_o
);
  import ppi_pkg::*;

  logic acc;

  // Stage 1: differences and sums.
  logic signed [32:0] s1x_e, s1y_e, s2x_e, s2y_e, dir_e;
  logic               s1_vld_q;
  logic signed [32:0] d1_q, d2_q, dx_q, dy_q, xsum1_q, spl1_q;
  logic signed [33:0] a1_q;
  logic signed [31:0] s1x1_q, s2x1_q;
  flags_t             flags1_q;

  // Stage 2: products.
  logic signed [64:0] m1_d, m2_d;
  logic signed [65:0] sxw, syw, p_d;
  logic               s2_vld_q;
  logic signed [64:0] m1_q, m2_q;
  logic [64:0]        sx_q, sy_q;
  logic signed [65:0] p_q;
  logic signed [33:0] a2_q;
  logic signed [32:0] xsum2_q, d12_q, spl2_q;
  logic signed [31:0] s1x2_q;
  flags_t             flags2_q;

  // Stage 3: B, Q, |D1*D2| and the discriminant sign.
  logic [65:0]        q_d;
  logic [64:0]        pm_d;
  sq_side_t           side3_d;
  logic               s3_vld_q;
  logic [65:0]        q_q;
  logic [64:0]        pm_q;
  sq_side_t           side3_q;

  // Stage 4 and 5: split wide product.
  logic               s4_vld_q, s5_vld_q;
  logic [65:0]        pp_ll_q, pp_lh_q;
  logic [64:0]        pp_hl_q, pp_hh_q;
  sq_side_t           side4_q, side5_q;
  logic [E_W-1:0]     e_q;

  // Square root.
  logic               sq_vld;
  logic [ROOT_W-1:0]  root;
  sq_side_t           sq_side;

  // Stage 6: x numerators and point count.
  logic signed [NUM_W-1:0] nb, sroot, n1_d, n2_d;
  logic signed [DEN_W-1:0] den6_d;
  logic [1:0]              cnt_d;
  xside_t                  xside_d;
  logic                    s6_vld_q;
  logic signed [NUM_W-1:0] n1_q, n2_q;
  logic signed [DEN_W-1:0] den6_q;
  xside_t                  xside6_q;

  // X dividers.
  logic                    xd_vld;
  logic signed [QUO_W-1:0] x1, x2;
  logic                    satx1, satx2;
  xside_t                  xs;

  // Stage 7 and 8: y numerators.
  logic signed [32:0]      dxa, dxb, d1y, sply;
  logic signed [65:0]      sqa_d, sqb_d, ds_d;
  logic                    s7_vld_q, s8_vld_q;
  logic signed [65:0]      sqa_q, sqb_q, ds_q;
  logic signed [32:0]      d17_q;
  yside_t                  yside7_q, yside8_q;
  logic signed [NUM_W-1:0] ny1_q, ny2_q;
  logic signed [DEN_W-1:0] den8_q;

  // Y dividers.
  logic                    yd_vld;
  logic signed [QUO_W-1:0] y1, y2;
  logic                    saty1, saty2;
  yside_t                  ys;

  // Result registers.
  logic                    sat_any;
  logic                    done_q;
  logic [1:0]              cnt_q;
  logic signed [31:0]      p1x_q, p1y_q, p2x_q, p2y_q;
  status_e                 status_q;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  assign s1x_e = {site1_x_i[31], site1_x_i};
  assign s1y_e = {site1_y_i[31], site1_y_i};
  assign s2x_e = {site2_x_i[31], site2_x_i};
  assign s2y_e = {site2_y_i[31], site2_y_i};
  assign dir_e = {directrix_y_i[31], directrix_y_i};

  // Valid bits of the stages in this module and of the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= sq_vld;
      s7_vld_q <= xd_vld;
      s8_vld_q <= s7_vld_q;
      done_q   <= yd_vld;
    end
  end

  // Stage 1: heights over the directrix and the case flags.
  always_ff @(posedge clk_i) begin
    d1_q     <= s1y_e - dir_e;
    d2_q     <= s2y_e - dir_e;
    a1_q     <= {s2y_e[32], s2y_e} - {s1y_e[32], s1y_e};
    dx_q     <= s1x_e - s2x_e;
    dy_q     <= s1y_e - s2y_e;
    xsum1_q  <= s1x_e + s2x_e;
    spl1_q   <= s1y_e + dir_e;
    s1x1_q   <= site1_x_i;
    s2x1_q   <= site2_x_i;
    flags1_q <= '{site:  (site1_y_i == directrix_y_i) || (site2_y_i == directrix_y_i),
                  azero: (site1_y_i == site2_y_i),
                  same:  (site1_x_i == site2_x_i),
                  eneg:  1'b0,
                  ezero: 1'b0};
  end

  // Stage 2: the five narrow products.
  always_comb begin
    m1_d = d1_q * s2x1_q;
    m2_d = d2_q * s1x1_q;
    sxw  = dx_q * dx_q;
    syw  = dy_q * dy_q;
    p_d  = d1_q * d2_q;
  end

  always_ff @(posedge clk_i) begin
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    sx_q     <= sxw[64:0];
    sy_q     <= syw[64:0];
    p_q      <= p_d;
    a2_q     <= a1_q;
    xsum2_q  <= xsum1_q;
    d12_q    <= d1_q;
    spl2_q   <= spl1_q;
    s1x2_q   <= s1x1_q;
    flags2_q <= flags1_q;
  end

  // Stage 3: linear coefficient, squared distance and discriminant sign.
  always_comb begin
    q_d  = {1'b0, sx_q} + {1'b0, sy_q};
    pm_d = p_q[65] ? 65'(~p_q + 66'sd1) : p_q[64:0];
    side3_d.b     = {m1_q[64], m1_q} - {m2_q[64], m2_q};
    side3_d.a     = a2_q;
    side3_d.xsum  = xsum2_q;
    side3_d.d1    = d12_q;
    side3_d.spl   = spl2_q;
    side3_d.s1x   = s1x2_q;
    side3_d.flags = flags2_q;
    side3_d.flags.ezero = (q_d == '0) || (p_q == '0);
    side3_d.flags.eneg  = p_q[65] && !side3_d.flags.ezero;
  end

  always_ff @(posedge clk_i) begin
    q_q     <= q_d;
    pm_q    <= pm_d;
    side3_q <= side3_d;
  end

  // Stage 4: four partial products of the discriminant.
  always_ff @(posedge clk_i) begin
    pp_ll_q <= pm_q[32:0] * q_q[32:0];
    pp_lh_q <= pm_q[32:0] * q_q[65:33];
    pp_hl_q <= pm_q[64:33] * q_q[32:0];
    pp_hh_q <= pm_q[64:33] * q_q[65:33];
    side4_q <= side3_q;
  end

  // Stage 5: sum of the partial products.
  always_ff @(posedge clk_i) begin
    e_q <= E_W'(pp_ll_q)
         + ((E_W'(pp_lh_q) + E_W'(pp_hl_q)) << 33)
         + (E_W'(pp_hh_q) << 66);
    side5_q <= side4_q;
  end

  ppi_sqrt #(
    .SB_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s5_vld_q),
    .rad_i  (e_q),
    .side_i (side5_q),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // Stage 6: numerators of the x quotients and the number of points.
  always_comb begin
    nb    = -{{(NUM_W - 66){sq_side.b[65]}}, sq_side.b};
    sroot = {{(NUM_W - ROOT_W){1'b0}}, root};
    n2_d  = nb + sroot;
    if (sq_side.flags.azero) begin
      n1_d   = {{(NUM_W - 33){sq_side.xsum[32]}}, sq_side.xsum};
      den6_d = DEN_W'(2);
    end else begin
      n1_d   = sq_side.flags.ezero ? nb : (nb - sroot);
      den6_d = sq_side.a;
    end
    if (sq_side.flags.site) begin
      cnt_d = 2'd0;
    end else if (sq_side.flags.azero) begin
      cnt_d = sq_side.flags.same ? 2'd0 : 2'd1;
    end else if (sq_side.flags.eneg) begin
      cnt_d = 2'd0;
    end else if (sq_side.flags.ezero) begin
      cnt_d = 2'd1;
    end else begin
      cnt_d = 2'd2;
    end
    xside_d.d1   = sq_side.d1;
    xside_d.spl  = sq_side.spl;
    xside_d.s1x  = sq_side.s1x;
    xside_d.cnt  = cnt_d;
    xside_d.site = sq_side.flags.site;
  end

  always_ff @(posedge clk_i) begin
    n1_q     <= n1_d;
    n2_q     <= n2_d;
    den6_q   <= den6_d;
    xside6_q <= xside_d;
  end

  ppi_div #(
    .SB_W ($bits(xside_t))
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s6_vld_q),
    .num1_i (n1_q),
    .num2_i (n2_q),
    .den_i  (den6_q),
    .side_i (xside6_q),
    .vld_o  (xd_vld),
    .quo1_o (x1),
    .quo2_o (x2),
    .sat1_o (satx1),
    .sat2_o (satx2),
    .side_o (xs)
  );

  // Stage 7: squares of the offsets from the first focus.
  always_comb begin
    d1y   = xs.d1;
    sply  = xs.spl;
    dxa   = {x1[31], x1} - {xs.s1x[31], xs.s1x};
    dxb   = {x2[31], x2} - {xs.s1x[31], xs.s1x};
    sqa_d = dxa * dxa;
    sqb_d = dxb * dxb;
    ds_d  = d1y * sply;
  end

  always_ff @(posedge clk_i) begin
    sqa_q         <= sqa_d;
    sqb_q         <= sqb_d;
    ds_q          <= ds_d;
    d17_q         <= xs.d1;
    yside7_q.x1   <= x1;
    yside7_q.x2   <= x2;
    yside7_q.sat1 <= satx1;
    yside7_q.sat2 <= satx2;
    yside7_q.cnt  <= xs.cnt;
    yside7_q.site <= xs.site;
  end

  // Stage 8: y numerators over the shared divisor 2*D1.
  always_ff @(posedge clk_i) begin
    ny1_q    <= {{(NUM_W - 66){sqa_q[65]}}, sqa_q} + {{(NUM_W - 66){ds_q[65]}}, ds_q};
    ny2_q    <= {{(NUM_W - 66){sqb_q[65]}}, sqb_q} + {{(NUM_W - 66){ds_q[65]}}, ds_q};
    den8_q   <= {d17_q, 1'b0};
    yside8_q <= yside7_q;
  end

  ppi_div #(
    .SB_W ($bits(yside_t))
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s8_vld_q),
    .num1_i (ny1_q),
    .num2_i (ny2_q),
    .den_i  (den8_q),
    .side_i (yside8_q),
    .vld_o  (yd_vld),
    .quo1_o (y1),
    .quo2_o (y2),
    .sat1_o (saty1),
    .sat2_o (saty2),
    .side_o (ys)
  );

  // Result assembly: unused points read as zero, saturation only counts
  // for points that are reported.
  assign sat_any = ((ys.cnt != 2'd0) && (ys.sat1 || saty1))
                || ((ys.cnt == 2'd2) && (ys.sat2 || saty2));

  always_ff @(posedge clk_i) begin
    cnt_q <= ys.cnt;
    p1x_q <= (ys.cnt != 2'd0) ? ys.x1 : '0;
    p1y_q <= (ys.cnt != 2'd0) ? y1 : '0;
    p2x_q <= (ys.cnt == 2'd2) ? ys.x2 : '0;
    p2y_q <= (ys.cnt == 2'd2) ? y2 : '0;
    if (ys.site) begin
      status_q <= ST_SITE;
    end else if (sat_any) begin
      status_q <= ST_SAT;
    end else begin
      status_q <= ST_OK;
    end
  end

  assign done_o        = done_q;
  assign point_count_o = cnt_q;
  assign point1_x_o    = p1x_q;
  assign point1_y_o    = p1y_q;
  assign point2_x_o    = p2x_q;
  assign point2_y_o    = p2y_q;
  assign status_o      = status_q;

  // Checks on entry and on the shape of results.
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, start && !busy, s1_vld_q)
  `ASSERT_IMPLIES(a_site_empty, clk_i, rst_ni, done_o && status_o == ST_SITE, point_count_o == 2'd0 && point1_x_o == '0 && point1_y_o == '0)
  `ASSERT_IMPLIES(a_second_unused, clk_i, rst_ni, done_o && point_count_o != 2'd2, point2_x_o == '0 && point2_y_o == '0)

endmodule
